FILE: sv/assert_macros.svh
// Assertion macros for the status frame decoder result stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define RSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define RSFD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/rsfd_pkg.sv
// Types and constants shared by the status frame decoder modules
package rsfd_pkg;

  // Request payload on the input channel
  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } rsfd_in_t;

  // Result payload on the output channel
  typedef struct packed {
    logic [4:0]         field_code;
    logic signed [31:0] field_value;
    logic [7:0]         sonar_slot;
    logic               stall_bit;
    logic               step_rejected;
    logic               frame_done;
  } rsfd_out_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_DISTANCE_SCALE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VELOCITY_SCALE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RANGE_SCALE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HEADING_SCALE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CONTROL_SCALE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_STEP       = 3'd5;

  // Field codes
  localparam logic [4:0] FC_STATUS  = 5'd0;
  localparam logic [4:0] FC_X       = 5'd1;
  localparam logic [4:0] FC_Y       = 5'd2;
  localparam logic [4:0] FC_HEADING = 5'd3;
  localparam logic [4:0] FC_LVEL    = 5'd4;
  localparam logic [4:0] FC_RVEL    = 5'd5;
  localparam logic [4:0] FC_BATTERY = 5'd6;
  localparam logic [4:0] FC_LSTALL  = 5'd7;
  localparam logic [4:0] FC_RSTALL  = 5'd8;
  localparam logic [4:0] FC_CONTROL = 5'd9;
  localparam logic [4:0] FC_PANTILT = 5'd10;
  localparam logic [4:0] FC_COMPASS = 5'd11;
  localparam logic [4:0] FC_SCOUNT  = 5'd12;
  localparam logic [4:0] FC_SONAR   = 5'd13;
  localparam logic [4:0] FC_TIMER   = 5'd14;
  localparam logic [4:0] FC_ANALOG  = 5'd15;
  localparam logic [4:0] FC_DIGIN   = 5'd16;
  localparam logic [4:0] FC_DIGOUT  = 5'd17;

  // Configuration register file contents
  typedef struct packed {
    logic [31:0] distance_scale;
    logic [31:0] velocity_scale;
    logic [31:0] range_scale;
    logic [31:0] heading_degree_scale;
    logic [31:0] control_radian_scale;
    logic [15:0] max_position_step;
  } rsfd_cfg_t;

  // How the back end finishes a field
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SIGNED,
    KIND_RANGE,
    KIND_POS
  } rsfd_kind_e;

  // Which scale factor multiplies the magnitude
  typedef enum logic [2:0] {
    SEL_DIST,
    SEL_VEL,
    SEL_RANGE,
    SEL_HEAD,
    SEL_CTRL
  } rsfd_scale_e;

  // Decoded field travelling down the pipeline
  typedef struct packed {
    rsfd_kind_e  kind;
    rsfd_scale_e sel;
    logic        neg;
    logic [15:0] mag;
    logic [15:0] value;
    logic [4:0]  code;
    logic [7:0]  slot;
    logic        stall;
    logic        done;
    logic        axis_y;
    logic        first;
  } rsfd_op_t;

endpackage

FILE: sv/rsfd_seq.sv
// Byte sequencer: tracks the frame layout and decodes each completed field
module rsfd_seq
  import rsfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      acc_i,
  input  rsfd_in_t  in_i,
  output logic      s1_valid_o,
  output rsfd_op_t  s1_op_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_X_LO, PH_X_HI, PH_Y_LO, PH_Y_HI, PH_H_LO, PH_H_HI,
    PH_LV_LO, PH_LV_HI, PH_RV_LO, PH_RV_HI, PH_BATT, PH_LSTALL, PH_RSTALL,
    PH_C_LO, PH_C_HI, PH_P_LO, PH_P_HI, PH_COMPASS, PH_SCOUNT, PH_SONAR,
    PH_T_LO, PH_T_HI, PH_ANALOG, PH_DIGIN, PH_DIGOUT
  } phase_e;

  localparam logic [7:0] CompassBadLo  = 8'd0;
  localparam logic [7:0] CompassBadMid = 8'd181;
  localparam logic [7:0] CompassBadHi  = 8'd255;

  typedef struct packed {
    logic        neg;
    logic [11:0] mag;
  } delta_t;

  phase_e      phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  rem_q, rem_d;
  logic [1:0]  epos_q, epos_d;
  logic [7:0]  idx_q, idx_d;
  logic [11:0] raw_x_q, raw_x_d;
  logic [11:0] raw_y_q, raw_y_d;
  logic        started_q, started_d;
  logic [8:0]  compass_q, compass_d;
  logic        s1_valid_q, s1_valid_d;
  rsfd_op_t    s1_op_q, s1_op_d;

  logic [7:0]  b;
  logic [15:0] word;
  logic [11:0] fresh;
  logic [7:0]  rem_dec;
  delta_t      dx, dy;

  // Shorter way round 4096; half a turn goes the other way
  function automatic delta_t unwrap(input logic [11:0] from, input logic [11:0] to);
    delta_t      d;
    logic [11:0] dm;
    dm    = to - from;
    d.mag = dm[11] ? (~dm + 12'd1) : dm;
    if (dm == 12'h800) begin
      d.neg = (to > from);
    end else begin
      d.neg = dm[11];
    end
    return d;
  endfunction

  assign b       = in_i.byte_value;
  assign word    = {b, held_q};
  assign fresh   = word[11:0];
  assign rem_dec = rem_q - 8'd1;
  assign dx      = unwrap(raw_x_q, fresh);
  assign dy      = unwrap(raw_y_q, fresh);

  // Advance the frame layout and build the field request
  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    rem_d      = rem_q;
    epos_d     = epos_q;
    idx_d      = idx_q;
    raw_x_d    = raw_x_q;
    raw_y_d    = raw_y_q;
    started_d  = started_q;
    compass_d  = compass_q;
    s1_valid_d = 1'b0;
    s1_op_d    = '0;
    s1_op_d.kind = KIND_PLAIN;
    s1_op_d.sel  = SEL_DIST;
    if (acc_i) begin
      if (in_i.frame_start) begin
        phase_d         = PH_X_LO;
        s1_valid_d      = 1'b1;
        s1_op_d.code    = FC_STATUS;
        s1_op_d.value   = {8'd0, b};
      end else begin
        case (phase_q)
          PH_X_LO: begin held_d = b; phase_d = PH_X_HI; end
          PH_Y_LO: begin held_d = b; phase_d = PH_Y_HI; end
          PH_H_LO: begin held_d = b; phase_d = PH_H_HI; end
          PH_LV_LO: begin held_d = b; phase_d = PH_LV_HI; end
          PH_RV_LO: begin held_d = b; phase_d = PH_RV_HI; end
          PH_C_LO: begin held_d = b; phase_d = PH_C_HI; end
          PH_P_LO: begin held_d = b; phase_d = PH_P_HI; end
          PH_T_LO: begin held_d = b; phase_d = PH_T_HI; end
          PH_X_HI: begin
            raw_x_d        = fresh;
            phase_d        = PH_Y_LO;
            s1_valid_d     = 1'b1;
            s1_op_d.kind   = KIND_POS;
            s1_op_d.code   = FC_X;
            s1_op_d.neg    = dx.neg;
            s1_op_d.mag    = {4'd0, dx.mag};
            s1_op_d.first  = !started_q;
          end
          PH_Y_HI: begin
            raw_y_d        = fresh;
            started_d      = 1'b1;
            phase_d        = PH_H_LO;
            s1_valid_d     = 1'b1;
            s1_op_d.kind   = KIND_POS;
            s1_op_d.code   = FC_Y;
            s1_op_d.neg    = dy.neg;
            s1_op_d.mag    = {4'd0, dy.mag};
            s1_op_d.axis_y = 1'b1;
            s1_op_d.first  = !started_q;
          end
          PH_H_HI, PH_LV_HI, PH_RV_HI, PH_C_HI: begin
            s1_valid_d   = 1'b1;
            s1_op_d.kind = KIND_SIGNED;
            s1_op_d.neg  = word[15];
            s1_op_d.mag  = word[15] ? (~word + 16'd1) : word;
            case (phase_q)
              PH_H_HI: begin
                phase_d = PH_LV_LO; s1_op_d.code = FC_HEADING; s1_op_d.sel = SEL_HEAD;
              end
              PH_LV_HI: begin
                phase_d = PH_RV_LO; s1_op_d.code = FC_LVEL; s1_op_d.sel = SEL_VEL;
              end
              PH_RV_HI: begin
                phase_d = PH_BATT; s1_op_d.code = FC_RVEL; s1_op_d.sel = SEL_VEL;
              end
              default: begin
                phase_d = PH_P_LO; s1_op_d.code = FC_CONTROL; s1_op_d.sel = SEL_CTRL;
              end
            endcase
          end
          PH_BATT: begin
            phase_d       = PH_LSTALL;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_BATTERY;
            s1_op_d.value = {8'd0, b};
          end
          PH_LSTALL, PH_RSTALL: begin
            phase_d       = (phase_q == PH_LSTALL) ? PH_RSTALL : PH_C_LO;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = (phase_q == PH_LSTALL) ? FC_LSTALL : FC_RSTALL;
            s1_op_d.value = {9'd0, b[7:1]};
            s1_op_d.stall = b[0];
          end
          PH_P_HI: begin
            phase_d       = PH_COMPASS;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_PANTILT;
            s1_op_d.value = word;
          end
          PH_COMPASS: begin
            if (b != CompassBadLo && b != CompassBadMid && b != CompassBadHi) begin
              compass_d = {b - 8'd1, 1'b0};
            end
            phase_d       = PH_SCOUNT;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_COMPASS;
            s1_op_d.value = {7'd0, compass_d};
          end
          PH_SCOUNT: begin
            rem_d         = b;
            epos_d        = 2'd0;
            phase_d       = (b == 8'd0) ? PH_T_LO : PH_SONAR;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_SCOUNT;
            s1_op_d.value = {8'd0, b};
          end
          PH_SONAR: begin
            case (epos_q)
              2'd0: begin idx_d = b; epos_d = 2'd1; end
              2'd1: begin held_d = b; epos_d = 2'd2; end
              default: begin
                epos_d       = 2'd0;
                rem_d        = rem_dec;
                if (rem_dec == 8'd0) begin
                  phase_d = PH_T_LO;
                end
                s1_valid_d   = 1'b1;
                s1_op_d.kind = KIND_RANGE;
                s1_op_d.sel  = SEL_RANGE;
                s1_op_d.code = FC_SONAR;
                s1_op_d.mag  = word;
                s1_op_d.slot = idx_q;
              end
            endcase
          end
          PH_T_HI: begin
            phase_d       = PH_ANALOG;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_TIMER;
            s1_op_d.value = word;
          end
          PH_ANALOG: begin
            phase_d       = PH_DIGIN;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_ANALOG;
            s1_op_d.value = {8'd0, b};
          end
          PH_DIGIN: begin
            phase_d       = PH_DIGOUT;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_DIGIN;
            s1_op_d.value = {8'd0, b};
          end
          PH_DIGOUT: begin
            phase_d       = PH_IDLE;
            s1_valid_d    = 1'b1;
            s1_op_d.code  = FC_DIGOUT;
            s1_op_d.value = {8'd0, b};
            s1_op_d.done  = 1'b1;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Hold frame state and the stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      held_q     <= '0;
      rem_q      <= '0;
      epos_q     <= '0;
      idx_q      <= '0;
      raw_x_q    <= '0;
      raw_y_q    <= '0;
      started_q  <= 1'b0;
      compass_q  <= '0;
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      rem_q      <= rem_d;
      epos_q     <= epos_d;
      idx_q      <= idx_d;
      raw_x_q    <= raw_x_d;
      raw_y_q    <= raw_y_d;
      started_q  <= started_d;
      compass_q  <= compass_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Field payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q <= s1_op_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_op_o    = s1_op_q;

endmodule

FILE: sv/rsfd_scale.sv
// Scaler: Q8.24 multiply in one stage, round to nearest even in the next
module rsfd_scale
  import rsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  rsfd_cfg_t   cfg_i,
  input  logic        s1_valid_i,
  input  rsfd_op_t    s1_op_i,
  output logic        s3_valid_o,
  output rsfd_op_t    s3_op_o,
  output logic [24:0] s3_q_o
);

  logic        s2_valid_q, s3_valid_q;
  rsfd_op_t    s2_op_q, s3_op_q;
  logic [31:0] scale;
  logic [47:0] prod_d, prod_q;
  logic [23:0] quo, rem;
  logic        up;
  logic [24:0] q_d, q_q;

  // Pick the factor for this field
  always_comb begin
    case (s1_op_i.sel)
      SEL_DIST:  scale = cfg_i.distance_scale;
      SEL_VEL:   scale = cfg_i.velocity_scale;
      SEL_RANGE: scale = cfg_i.range_scale;
      SEL_HEAD:  scale = cfg_i.heading_degree_scale;
      SEL_CTRL:  scale = cfg_i.control_radian_scale;
      default:   scale = cfg_i.distance_scale;
    endcase
  end

  assign prod_d = 48'(s1_op_i.mag) * 48'(scale);

  // Round the product, ties to even
  assign quo = prod_q[47:24];
  assign rem = prod_q[23:0];
  assign up  = (rem > 24'h800000) || ((rem == 24'h800000) && quo[0]);
  assign q_d = {1'b0, quo} + 25'(up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_op_q <= s1_op_i;
      prod_q  <= prod_d;
      s3_op_q <= s2_op_q;
      q_q     <= q_d;
    end
  end

  assign s3_valid_o = s3_valid_q;
  assign s3_op_o    = s3_op_q;
  assign s3_q_o     = q_q;

endmodule

FILE: sv/rsfd_out.sv
// Result stage: finishes each field, keeps the positions, holds the result
module rsfd_out
  import rsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [15:0] max_step_i,
  input  logic        s3_valid_i,
  input  rsfd_op_t    s3_op_i,
  input  logic [24:0] s3_q_i,
  output logic        out_valid_o,
  output rsfd_out_t   out_data_o
);

  `include "assert_macros.svh"

  logic        out_valid_q;
  rsfd_out_t   out_q, out_d;
  logic [31:0] x_q, x_d, y_q, y_d;
  logic [31:0] pos_old, pos_new, q32;
  logic [15:0] low16;
  logic        rej;

  assign q32     = {7'd0, s3_q_i};
  assign low16   = s3_op_i.neg ? (~s3_q_i[15:0] + 16'd1) : s3_q_i[15:0];
  assign pos_old = s3_op_i.axis_y ? y_q : x_q;
  assign rej     = !s3_op_i.first && (s3_q_i > {9'd0, max_step_i});

  // Zero on the first frame, drop an oversized step, else add it
  always_comb begin
    if (s3_op_i.first) begin
      pos_new = '0;
    end else if (rej) begin
      pos_new = pos_old;
    end else if (s3_op_i.neg) begin
      pos_new = pos_old - q32;
    end else begin
      pos_new = pos_old + q32;
    end
  end

  // Build the result and the position updates
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    out_d.field_code    = s3_op_i.code;
    out_d.sonar_slot    = s3_op_i.slot;
    out_d.stall_bit     = s3_op_i.stall;
    out_d.frame_done    = s3_op_i.done;
    out_d.step_rejected = 1'b0;
    case (s3_op_i.kind)
      KIND_SIGNED: out_d.field_value = $signed({{16{low16[15]}}, low16});
      KIND_RANGE:  out_d.field_value = $signed({16'd0, s3_q_i[15:0]});
      KIND_POS: begin
        out_d.field_value   = $signed(pos_new);
        out_d.step_rejected = rej;
        if (s3_valid_i) begin
          if (s3_op_i.axis_y) begin
            y_d = pos_new;
          end else begin
            x_d = pos_new;
          end
        end
      end
      default:     out_d.field_value = $signed({16'd0, s3_op_i.value});
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
    end else if (en_i) begin
      out_valid_q <= s3_valid_i;
      x_q         <= x_d;
      y_q         <= y_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RSFD_ASSERT(a_rej_pos, (out_valid_q && out_q.step_rejected) |-> (out_q.field_code == FC_X || out_q.field_code == FC_Y), "step rejection outside a position field")
  `RSFD_ASSERT(a_done_code, (out_valid_q && out_q.frame_done) |-> (out_q.field_code == FC_DIGOUT), "frame done on a field other than digital out")
  `RSFD_ASSERT(a_pos_hold, (!en_i) |=> ($stable(x_q) && $stable(y_q)), "position moved while the pipeline was held")
  `RSFD_NEVER(a_rej_moves, en_i && s3_valid_i && s3_op_i.kind == KIND_POS && rej && pos_new != pos_old, "rejected step changed the position")

endmodule

FILE: sv/robot_status_frame_decoder.sv
// Robot status frame decoder: one frame body byte per request, one result per completed field.
// Takes a byte every cycle unless the pipeline is held; the request that completes a field
// passes through a sequencer, a multiply stage, a rounding stage and the result register, and the
// whole pipeline holds only while a finished result waits on a stalled output. The X and Y
// positions are updated in the result stage; no clearing pass follows reset.
module robot_status_frame_decoder
  import rsfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rsfd_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsfd_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  rsfd_cfg_t   cfg_q;
  logic        en, acc;
  logic        s1_valid, s3_valid;
  rsfd_op_t    s1_op, s3_op;
  logic [24:0] s3_q;

  // Advance every stage unless a finished result is held back
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.distance_scale       <= 32'd16777216;
      cfg_q.velocity_scale       <= 32'd16777216;
      cfg_q.range_scale          <= 32'd16777216;
      cfg_q.heading_degree_scale <= 32'd1474560;
      cfg_q.control_radian_scale <= 32'd25736;
      cfg_q.max_position_step    <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DISTANCE_SCALE: cfg_q.distance_scale       <= cfg_wdata_i;
        REG_VELOCITY_SCALE: cfg_q.velocity_scale       <= cfg_wdata_i;
        REG_RANGE_SCALE:    cfg_q.range_scale          <= cfg_wdata_i;
        REG_HEADING_SCALE:  cfg_q.heading_degree_scale <= cfg_wdata_i;
        REG_CONTROL_SCALE:  cfg_q.control_radian_scale <= cfg_wdata_i;
        REG_MAX_STEP:       cfg_q.max_position_step    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  rsfd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .acc_i      (acc),
    .in_i       (in_data_i),
    .s1_valid_o (s1_valid),
    .s1_op_o    (s1_op)
  );

  rsfd_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .s1_valid_i (s1_valid),
    .s1_op_i    (s1_op),
    .s3_valid_o (s3_valid),
    .s3_op_o    (s3_op),
    .s3_q_o     (s3_q)
  );

  rsfd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .max_step_i  (cfg_q.max_position_step),
    .s3_valid_i  (s3_valid),
    .s3_op_i     (s3_op),
    .s3_q_i      (s3_q),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the robot status frame decoder
`timescale 1ns / 1ps

module tb_top;
  import rsfd_pkg::*;

  // Timing of the run
  localparam int    HALF_PERIOD     = 4;
  localparam int    RESET_CYCLES    = 8;
  localparam int    PIPE_LATENCY    = 4;
  localparam int    SETTLE_CYCLES   = 4 * PIPE_LATENCY;
  localparam int    HOLD_CYCLES     = 300;
  localparam int    MAX_REPORTS     = 40;
  localparam longint TIMEOUT_NS     = 4_000_000;

  // Shape of the random part
  localparam int CFG_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 150;

  // Register values after reset
  localparam logic [31:0] RST_DISTANCE_SCALE = 32'd16777216;
  localparam logic [31:0] RST_VELOCITY_SCALE = 32'd16777216;
  localparam logic [31:0] RST_RANGE_SCALE    = 32'd16777216;
  localparam logic [31:0] RST_HEADING_SCALE  = 32'd1474560;
  localparam logic [31:0] RST_CONTROL_SCALE  = 32'd25736;
  localparam logic [31:0] RST_MAX_STEP       = 32'd100;

  // Indexes past the end of the register list
  localparam logic [CfgIdxW-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_B = 3'd7;

  // Encoder and compass constants
  localparam logic [15:0] ENC_MASK      = 16'hEFFF;
  localparam int          COUNT_TURN    = 4096;
  localparam logic [23:0] ROUND_HALF    = 24'h800000;
  localparam logic [7:0]  COMPASS_BLANK [3] = '{8'd0, 8'd181, 8'd255};
  localparam logic [15:0] WORD_EDGES    [5] =
    '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};

  // Position in the frame body
  typedef enum logic [4:0] {
    ST_IDLE, ST_X_LO, ST_X_HI, ST_Y_LO, ST_Y_HI, ST_H_LO, ST_H_HI,
    ST_LV_LO, ST_LV_HI, ST_RV_LO, ST_RV_HI, ST_BATT, ST_LSTALL, ST_RSTALL,
    ST_C_LO, ST_C_HI, ST_P_LO, ST_P_HI, ST_COMPASS, ST_SCOUNT, ST_SONAR,
    ST_T_LO, ST_T_HI, ST_ANALOG, ST_DIGIN, ST_DIGOUT
  } phase_e;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // One row of the directed table
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        typed;
    logic [4:0]  code;
    logic [31:0] value;
    logic [7:0]  slot;
    logic        stall;
    logic        rejected;
    logic        done;
  } dir_row_t;

  // Directed frames at reset settings; typed rows carry their result
  localparam int DIR_ROWS = 31;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h5A, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h12, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, FC_STATUS,  32'd255,       8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_X,       32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, FC_Y,       32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, FC_HEADING, 32'hFFFF_F4C0, 8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h7F, 1'b0, 1'b1, FC_LVEL,    32'd32767,     8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, FC_RVEL,    32'hFFFF_8000, 8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_BATTERY, 32'd255,       8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_LSTALL,  32'd127,       8'd0,   1'b1, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, FC_RSTALL,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h34, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hC2, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_PANTILT, 32'd65535,     8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_COMPASS, 32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b1, FC_SCOUNT,  32'd1,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_SONAR,   32'd65535,     8'd255, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, FC_STATUS,  32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_TIMER,   32'd65280,     8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_ANALOG,  32'd255,       8'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, FC_DIGIN,   32'd0,         8'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b1, FC_DIGOUT,  32'd255,       8'd0,   1'b0, 1'b0, 1'b1}
  };

  // Block ports, all known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  rsfd_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rsfd_out_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_wdata_i = '0;

  // Decoder state as the testbench sees it
  logic [31:0] distance_scale, velocity_scale, range_scale;
  logic [31:0] heading_scale, control_scale;
  logic [15:0] max_step;
  phase_e      byte_phase;
  logic [7:0]  held_low_byte, sonar_left, sonar_index;
  logic [1:0]  sonar_pos;
  logic [11:0] raw_x_count, raw_y_count;
  logic [31:0] x_position, y_position;
  logic        position_started;
  logic [8:0]  compass_heading;

  // Fields still to come out of the block, oldest first
  rsfd_out_t   expected_fields [$];
  rsfd_in_t    frame_bytes [$];
  int          mismatch_count  = 0;
  int          holds_requested = 0;
  int          burst_left      = 0;
  logic [11:0] gen_x_raw       = '0;
  logic [11:0] gen_y_raw       = '0;

  robot_status_frame_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Return the decoder state to its reset values
  function automatic void reset_model();
    distance_scale   = RST_DISTANCE_SCALE;
    velocity_scale   = RST_VELOCITY_SCALE;
    range_scale      = RST_RANGE_SCALE;
    heading_scale    = RST_HEADING_SCALE;
    control_scale    = RST_CONTROL_SCALE;
    max_step         = RST_MAX_STEP[15:0];
    byte_phase       = ST_IDLE;
    held_low_byte    = '0;
    sonar_left       = '0;
    sonar_pos        = '0;
    sonar_index      = '0;
    raw_x_count      = '0;
    raw_y_count      = '0;
    x_position       = '0;
    y_position       = '0;
    position_started = 1'b0;
    compass_heading  = '0;
  endfunction

  // Mirror a register write; unknown indexes fall through
  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_DISTANCE_SCALE: distance_scale = val;
      REG_VELOCITY_SCALE: velocity_scale = val;
      REG_RANGE_SCALE:    range_scale    = val;
      REG_HEADING_SCALE:  heading_scale  = val;
      REG_CONTROL_SCALE:  control_scale  = val;
      REG_MAX_STEP:       max_step       = val[15:0];
      default: ;
    endcase
  endfunction

  // Divide by 2^24, rounding to nearest with ties to even
  function automatic logic [63:0] round_q24(input logic [63:0] prod);
    logic [63:0] q;
    logic [23:0] r;
    q = prod >> 24;
    r = prod[23:0];
    if (r > ROUND_HALF || (r == ROUND_HALF && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Signed magnitude times a Q8.24 factor, rounded, wrapped to 32 bits
  function automatic logic [31:0] scale_mag(input logic neg, input logic [31:0] mag,
                                            input logic [31:0] scale);
    logic [63:0] q;
    q = round_q24(64'(mag) * 64'(scale));
    return neg ? 32'd0 - q[31:0] : q[31:0];
  endfunction

  // 16-bit signed word scaled and folded back to 16-bit signed
  function automatic logic [31:0] scale_signed_word(input logic [15:0] word,
                                                    input logic [31:0] scale);
    logic [31:0] mag, v;
    mag = word[15] ? 32'h10000 - 32'(word) : 32'(word);
    v   = scale_mag(word[15], mag, scale);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  // Shorter way round from one 12-bit count to the next; half a turn flips
  function automatic int count_step(input logic [11:0] from, input logic [11:0] to);
    int d1, d2, a1, a2;
    d1 = int'(to) - int'(from);
    d2 = (to > from) ? d1 - COUNT_TURN : d1 + COUNT_TURN;
    a1 = (d1 < 0) ? -d1 : d1;
    a2 = (d2 < 0) ? -d2 : d2;
    return (a1 < a2) ? d1 : d2;
  endfunction

  // Advance one position from a new encoder word; flag an oversized step
  function automatic logic track_axis(input logic [15:0] word, inout logic [11:0] raw,
                                      inout logic [31:0] pos);
    logic [11:0] fresh;
    logic [31:0] mag;
    logic [63:0] q;
    logic        rej;
    int          d;
    fresh = 12'(word & ENC_MASK);
    rej   = 1'b0;
    if (!position_started) begin
      pos = '0;
    end else begin
      d   = count_step(raw, fresh);
      mag = (d < 0) ? 32'(-d) : 32'(d);
      q   = round_q24(64'(mag) * 64'(distance_scale));
      if (q > 64'(max_step)) rej = 1'b1;
      else if (d < 0) pos = pos - q[31:0];
      else pos = pos + q[31:0];
    end
    raw = fresh;
    return rej;
  endfunction

  // Take one byte into the decoder state; return 1 when a field completes
  function automatic logic decode_byte(input rsfd_in_t req, output rsfd_out_t res);
    logic [7:0]  b;
    logic [15:0] word;
    phase_e      ph;
    b    = req.byte_value;
    word = {b, held_low_byte};
    ph   = byte_phase;
    res  = '0;
    if (req.frame_start) begin
      byte_phase      = ST_X_LO;
      res.field_code  = FC_STATUS;
      res.field_value = 32'(b);
      return 1'b1;
    end
    case (ph)
      ST_X_LO, ST_Y_LO, ST_H_LO, ST_LV_LO, ST_RV_LO, ST_C_LO, ST_P_LO, ST_T_LO: begin
        held_low_byte = b;
        byte_phase    = phase_e'(ph + 5'd1);
        return 1'b0;
      end
      ST_X_HI: begin
        res.step_rejected = track_axis(word, raw_x_count, x_position);
        res.field_code    = FC_X;
        res.field_value   = x_position;
        byte_phase        = ST_Y_LO;
      end
      ST_Y_HI: begin
        res.step_rejected = track_axis(word, raw_y_count, y_position);
        position_started  = 1'b1;
        res.field_code    = FC_Y;
        res.field_value   = y_position;
        byte_phase        = ST_H_LO;
      end
      ST_H_HI: begin
        res.field_code  = FC_HEADING;
        res.field_value = scale_signed_word(word, heading_scale);
        byte_phase      = ST_LV_LO;
      end
      ST_LV_HI: begin
        res.field_code  = FC_LVEL;
        res.field_value = scale_signed_word(word, velocity_scale);
        byte_phase      = ST_RV_LO;
      end
      ST_RV_HI: begin
        res.field_code  = FC_RVEL;
        res.field_value = scale_signed_word(word, velocity_scale);
        byte_phase      = ST_BATT;
      end
      ST_BATT: begin
        res.field_code  = FC_BATTERY;
        res.field_value = 32'(b);
        byte_phase      = ST_LSTALL;
      end
      ST_LSTALL, ST_RSTALL: begin
        res.field_code  = (ph == ST_LSTALL) ? FC_LSTALL : FC_RSTALL;
        res.field_value = 32'(b >> 1);
        res.stall_bit   = b[0];
        byte_phase      = (ph == ST_LSTALL) ? ST_RSTALL : ST_C_LO;
      end
      ST_C_HI: begin
        res.field_code  = FC_CONTROL;
        res.field_value = scale_signed_word(word, control_scale);
        byte_phase      = ST_P_LO;
      end
      ST_P_HI: begin
        res.field_code  = FC_PANTILT;
        res.field_value = 32'(word);
        byte_phase      = ST_COMPASS;
      end
      ST_COMPASS: begin
        // Hold the old heading on the no-reading bytes
        if (b != COMPASS_BLANK[0] && b != COMPASS_BLANK[1] && b != COMPASS_BLANK[2])
          compass_heading = {b - 8'd1, 1'b0};
        res.field_code  = FC_COMPASS;
        res.field_value = 32'(compass_heading);
        byte_phase      = ST_SCOUNT;
      end
      ST_SCOUNT: begin
        sonar_left      = b;
        sonar_pos       = 2'd0;
        res.field_code  = FC_SCOUNT;
        res.field_value = 32'(b);
        byte_phase      = (b == 8'd0) ? ST_T_LO : ST_SONAR;
      end
      ST_SONAR: begin
        if (sonar_pos == 2'd0) begin
          sonar_index = b;
          sonar_pos   = 2'd1;
          return 1'b0;
        end
        if (sonar_pos == 2'd1) begin
          held_low_byte = b;
          sonar_pos     = 2'd2;
          return 1'b0;
        end
        sonar_pos  = 2'd0;
        sonar_left = sonar_left - 8'd1;
        if (sonar_left == 8'd0) byte_phase = ST_T_LO;
        res.field_code  = FC_SONAR;
        res.field_value = scale_mag(1'b0, 32'(word), range_scale) & 32'h0000_FFFF;
        res.sonar_slot  = sonar_index;
      end
      ST_T_HI: begin
        res.field_code  = FC_TIMER;
        res.field_value = 32'(word);
        byte_phase      = ST_ANALOG;
      end
      ST_ANALOG: begin
        res.field_code  = FC_ANALOG;
        res.field_value = 32'(b);
        byte_phase      = ST_DIGIN;
      end
      ST_DIGIN: begin
        res.field_code  = FC_DIGIN;
        res.field_value = 32'(b);
        byte_phase      = ST_DIGOUT;
      end
      ST_DIGOUT: begin
        res.field_code  = FC_DIGOUT;
        res.field_value = 32'(b);
        res.frame_done  = 1'b1;
        byte_phase      = ST_IDLE;
      end
      default: begin
        // Drop bytes that arrive outside a frame
        byte_phase = ST_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Frame building helpers
  function automatic void push_byte(input logic [7:0] b, input logic start);
    rsfd_in_t req;
    req.byte_value = b;
    req.frame_start = start;
    frame_bytes.push_back(req);
  endfunction

  function automatic void push_word(input logic [15:0] w);
    push_byte(w[7:0], 1'b0);
    push_byte(w[15:8], 1'b0);
  endfunction

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 3) == 0) return WORD_EDGES[$urandom_range(0, 4)];
    return 16'($urandom());
  endfunction

  // Next encoder word: small moves, half turns, moves near the limit, jumps
  function automatic logic [15:0] next_count_word(inout logic [11:0] last);
    int d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = int'($urandom_range(0, 40)) - 20;
      4:          d = COUNT_TURN / 2;
      5, 6:       d = ($urandom_range(0, 1) != 0) ? int'($urandom_range(90, 140))
                                                  : -int'($urandom_range(90, 140));
      default:    d = int'($urandom_range(0, COUNT_TURN - 1));
    endcase
    last = last + 12'(d);
    return {4'($urandom()), last};
  endfunction

  // Fill frame_bytes with one frame, maybe noise first and maybe cut short;
  // return the number of frame bytes
  function automatic int build_frame(input logic big_sonar);
    int noise, n_sonar, cut;
    frame_bytes.delete();
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom()), 1'b0);
    noise = frame_bytes.size();
    push_byte(8'($urandom()), 1'b1);
    push_word(next_count_word(gen_x_raw));
    push_word(next_count_word(gen_y_raw));
    repeat (3) push_word(pick_word());
    repeat (3) push_byte(8'($urandom()), 1'b0);
    push_word(pick_word());
    push_word(16'($urandom()));
    if ($urandom_range(0, 3) == 0) push_byte(COMPASS_BLANK[$urandom_range(0, 2)], 1'b0);
    else push_byte(8'($urandom()), 1'b0);
    if (big_sonar) n_sonar = $urandom_range(128, 160);
    else if ($urandom_range(0, 2) == 0) n_sonar = 0;
    else n_sonar = $urandom_range(1, 4);
    push_byte(8'(n_sonar), 1'b0);
    repeat (n_sonar) begin
      push_byte(8'($urandom()), 1'b0);
      push_word(pick_word());
    end
    push_word(16'($urandom()));
    repeat (3) push_byte(8'($urandom()), 1'b0);
    // Cut some frames so the next status byte lands mid-frame
    if (!big_sonar && $urandom_range(0, 11) == 0) begin
      cut = $urandom_range(noise + 1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    return frame_bytes.size() - noise;
  endfunction

  // Offer one request in bursts with random gaps; predict on acceptance
  task automatic send_item(input rsfd_in_t req, input logic use_typed,
                           input rsfd_out_t typed_res);
    rsfd_out_t res;
    logic      has_res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    has_res = decode_byte(req, res);
    if (use_typed) expected_fields.push_back(typed_res);
    else if (has_res) expected_fields.push_back(res);
  endtask

  // Stop offering, wait for every field, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_cfg(idx, val);
  endtask

  // Load one register setting: extremes first, then reset values, then random
  task automatic load_settings(input int phase);
    logic [31:0] vals [6];
    for (int i = 0; i < 6; i++) begin
      case (phase)
        0: vals[i] = 32'hFFFF_FFFF;
        1: vals[i] = 32'd0;
        default: begin
          if ($urandom_range(0, 2) == 0) vals[i] = $urandom();
          else vals[i] = $urandom_range(32'h0040_0000, 32'h0400_0000);
        end
      endcase
    end
    if (phase == 2) begin
      vals = '{RST_DISTANCE_SCALE, RST_VELOCITY_SCALE, RST_RANGE_SCALE,
               RST_HEADING_SCALE, RST_CONTROL_SCALE, RST_MAX_STEP};
    end else if (phase > 2) begin
      vals[REG_MAX_STEP] = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 400) : $urandom();
    end
    for (int i = 0; i < 6; i++) reg_write(CfgIdxW'(i), vals[i]);
    reg_write(REG_UNUSED_A, $urandom());
    reg_write(REG_UNUSED_B, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
               $time, name, want, got);
    mismatch_count++;
  endtask

  // Compare one accepted result with the oldest expected field
  task automatic check_field(input rsfd_out_t got);
    rsfd_out_t want;
    if (expected_fields.size() == 0) begin
      report_field("unexpected result, code", 32'hFFFF_FFFF, 32'(got.field_code));
      return;
    end
    want = expected_fields.pop_front();
    if (got.field_code !== want.field_code)
      report_field("field_code", 32'(want.field_code), 32'(got.field_code));
    if (got.field_value !== want.field_value)
      report_field("field_value", want.field_value, got.field_value);
    if (got.sonar_slot !== want.sonar_slot)
      report_field("sonar_slot", 32'(want.sonar_slot), 32'(got.sonar_slot));
    if (got.stall_bit !== want.stall_bit)
      report_field("stall_bit", 32'(want.stall_bit), 32'(got.stall_bit));
    if (got.step_rejected !== want.step_rejected)
      report_field("step_rejected", 32'(want.step_rejected), 32'(got.step_rejected));
    if (got.frame_done !== want.frame_done)
      report_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_field(out_data_o);
  end

  // Receiver: stall in changing patterns, with a long hold-off on request
  initial begin : result_side
    stall_mode_e mode;
    int          mode_left, hold_left, tick, holds_served;
    mode         = STALL_NONE;
    mode_left    = 0;
    hold_left    = 0;
    tick         = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (holds_served != holds_requested) begin
        holds_served = holds_requested;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Stimulus: directed table, then random frames under several settings
  initial begin : request_side
    dir_row_t  row;
    rsfd_in_t  req;
    rsfd_out_t typed_res;
    int        sent;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row             = DIR_TABLE[i];
      req.byte_value  = row.data;
      req.frame_start = row.start;
      typed_res       = '{row.code, row.value, row.slot, row.stall, row.rejected, row.done};
      send_item(req, row.typed, typed_res);
    end
    settle();

    for (int p = 0; p < CFG_PHASES; p++) begin
      load_settings(p);
      // Hold the output off for a while so the pipeline backs up
      if (p == 2 || p == 6) holds_requested++;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        sent += build_frame(p == 3 && sent == 0);
        foreach (frame_bytes[i]) send_item(frame_bytes[i], 1'b0, '0);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
